// ===== hw/rtl/ald_pkg.sv =====
// Shared types, codes and the channel blend function for the line drawer.
// No dependencies; used by antialiased_line_drawer.
package ald_pkg;

  localparam int FB_WIDTH_DEF  = 32;
  localparam int FB_HEIGHT_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 5;
  localparam int RGB_W         = 24;

  typedef enum logic [1:0] {
    REQ_LINE  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_PLOT0,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_A_RD,
    ST_A_WR,
    ST_B_RD,
    ST_B_WR,
    ST_PLOT1,
    ST_RD_ISSUE,
    ST_RD_EMIT,
    ST_FLUSH
  } state_t;

  // Mix colour col over stored bg; cw is the colour weight, 256 means solid.
  function automatic logic [RGB_W-1:0] blend_px(input logic [RGB_W-1:0] bg,
                                                input logic [RGB_W-1:0] col,
                                                input logic [8:0] cw);
    logic [RGB_W-1:0] res;
    logic [8:0]       bw;
    logic [16:0]      tb;
    logic [16:0]      tc;
    res = '0;
    bw  = 9'd256 - cw;
    for (int ch = 0; ch < 3; ch++) begin
      tb = 17'(bw) * 17'(bg[ch*8 +: 8]);
      tc = 17'(cw) * 17'(col[ch*8 +: 8]);
      res[ch*8 +: 8] = tb[15:8] + tc[15:8];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/ald_div.sv =====
// Restoring divider, one quotient bit per cycle, for the line slope.
// Depends on nothing; instantiated by antialiased_line_drawer.
module ald_div #(
  parameter int W = 21
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [4:0]   divisor,
  output logic         done,
  output logic [W-1:0] quot
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]  dq;
  logic [4:0]    rem;
  logic [CW-1:0] cnt;
  logic          run;
  logic [5:0]    rem_sh;
  logic [5:0]    diff;
  logic          ge;

  assign rem_sh = {rem, dq[W-1]};
  assign ge     = rem_sh >= {1'b0, divisor};
  assign diff   = rem_sh - {1'b0, divisor};
  assign quot   = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W-1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
    end else if (run) begin
      dq  <= {dq[W-2:0], ge};
      rem <= ge ? diff[4:0] : rem_sh[4:0];
    end
  end

endmodule

// ===== hw/rtl/antialiased_line_drawer.sv =====
// Top level of the anti-aliased line drawer: sequencer, frame store, result queue.
// Depends on ald_pkg and ald_div.
//
// After reset the block sweeps the frame store to zero, one pixel a cycle, and
// in_ready stays low until the sweep has covered all FB_WIDTH*FB_HEIGHT pixels.
// A request word then carries a line, a pixel write or a pixel read. A line
// first runs its setup, dominated by the serial slope divider that produces
// one quotient bit a cycle, and then visits each middle step of the dominant
// axis: each step reads, blends and writes back two pixels through the
// single-port-read frame store, whose read data arrives in the cycle after the
// address. Every pixel written or read returns one result word; the final word
// of a request carries last. Results are held one deep so last can be set
// correctly even when trailing pixels fall off the store; a stalled output side
// holds the sequencer only when a new word must be pushed.
module antialiased_line_drawer #(
  parameter int FB_WIDTH  = ald_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = ald_pkg::FB_HEIGHT_DEF,
  parameter int FRAC_BITS = ald_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [4:0]  x_start,
  input  logic [4:0]  y_start,
  input  logic [4:0]  x_end,
  input  logic [4:0]  y_end,
  input  logic [23:0] color_rgb,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  pix_x,
  output logic [4:0]  pix_y,
  output logic [23:0] pix_rgb,
  output logic        last
);

  localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = FRAC_BITS + 5;   // dividend: |dmin| << FRAC_BITS
  localparam int PW    = FRAC_BITS + 7;   // signed minor position

  // Frame store.
  logic [23:0] mem [DEPTH];
  logic [23:0] rdata;
  logic        re;
  logic        we;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [23:0]   wdata;

  ald_pkg::state_t state;
  ald_pkg::state_t state_next;

  // Request registers.
  logic [1:0]  rtype;
  logic [4:0]  xs, ys, xe, ye;
  logic [23:0] col;

  // Line setup.
  logic       xdom;
  logic [4:0] ma0;
  logic [4:0] mi0;
  logic [4:0] dmaj;
  logic [4:0] dmin_mag;
  logic       dmin_neg;
  logic [4:0] step;
  logic signed [PW-1:0] pos;
  logic signed [PW-1:0] kslope;

  logic [AW-1:0] clr_cnt;

  // Result queue: one pending word plus the output register.
  logic        pend_valid;
  logic [4:0]  pend_x, pend_y;
  logic [23:0] pend_rgb;

  // Divider.
  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_quot;

  ald_div #(.W(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({dmin_mag, FRAC_BITS'(0)}),
    .divisor  (dmaj),
    .done     (div_done),
    .quot     (div_quot)
  );

  function automatic logic in_store(input logic [5:0] x, input logic [5:0] y);
    return (32'(x) < FB_WIDTH) && (32'(y) < FB_HEIGHT);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [5:0] x, input logic [5:0] y);
    return AW'(32'(y) * FB_WIDTH + 32'(x));
  endfunction

  // Setup arithmetic from the registered request.
  logic signed [5:0] dx, dy;
  logic [5:0] adx, ady;
  logic       xdom_c;
  logic [4:0] a0, a1, n0, n1;
  logic       swp;
  logic signed [5:0] dmin_c;

  always_comb begin
    dx     = $signed({1'b0, xe}) - $signed({1'b0, xs});
    dy     = $signed({1'b0, ye}) - $signed({1'b0, ys});
    adx    = dx[5] ? 6'(-dx) : 6'(dx);
    ady    = dy[5] ? 6'(-dy) : 6'(dy);
    xdom_c = adx > ady;
    a0     = xdom_c ? xs : ys;
    a1     = xdom_c ? xe : ye;
    n0     = xdom_c ? ys : xs;
    n1     = xdom_c ? ye : xe;
    swp    = a1 < a0;
    dmin_c = swp ? ($signed({1'b0, n0}) - $signed({1'b0, n1}))
                 : ($signed({1'b0, n1}) - $signed({1'b0, n0}));
  end

  // Per-step geometry.
  logic        phase_b;
  logic [5:0]  mcoord;
  logic [5:0]  minor;
  logic [5:0]  major;
  logic [5:0]  bx, by;
  logic [7:0]  wfrac;
  logic [8:0]  cw;
  logic        b_in;
  logic        last_step;
  logic [23:0] blend_rgb;

  always_comb begin
    phase_b   = (state == ald_pkg::ST_B_RD) || (state == ald_pkg::ST_B_WR);
    mcoord    = pos[FRAC_BITS +: 6];
    minor     = phase_b ? mcoord + 6'd1 : mcoord;
    major     = {1'b0, ma0 + step};
    bx        = xdom ? major : minor;
    by        = xdom ? minor : major;
    wfrac     = pos[FRAC_BITS-1 -: 8];
    cw        = phase_b ? {1'b0, wfrac} : 9'd256 - {1'b0, wfrac};
    b_in      = in_store(bx, by) && !pos[PW-1];
    last_step = step == dmaj - 5'd1;
    blend_rgb = ald_pkg::blend_px(rdata, col, cw);
  end

  // Endpoint and single-pixel geometry.
  logic [4:0] pl_x, pl_y;
  logic       pl_in;
  logic       rd_in;
  logic       can_take;
  logic       out_free;

  assign pl_x     = (state == ald_pkg::ST_PLOT0) ? xs : xe;
  assign pl_y     = (state == ald_pkg::ST_PLOT0) ? ys : ye;
  assign pl_in    = in_store({1'b0, pl_x}, {1'b0, pl_y});
  assign rd_in    = in_store({1'b0, xs}, {1'b0, ys});
  assign out_free = !out_valid || out_ready;
  assign can_take = !pend_valid || out_free;
  assign in_ready = state == ald_pkg::ST_IDLE;

  assign kslope = dmin_neg ? -PW'(div_quot) : PW'(div_quot);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ald_pkg::ST_CLEAR: begin
        if (clr_cnt == AW'(DEPTH-1)) state_next = ald_pkg::ST_IDLE;
      end
      ald_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (req_type)
            ald_pkg::REQ_LINE:  state_next = ald_pkg::ST_SETUP;
            ald_pkg::REQ_WRITE: state_next = ald_pkg::ST_PLOT1;
            ald_pkg::REQ_READ:  state_next = ald_pkg::ST_RD_ISSUE;
            default:            state_next = ald_pkg::ST_FLUSH;
          endcase
        end
      end
      ald_pkg::ST_SETUP: state_next = ald_pkg::ST_PLOT0;
      ald_pkg::ST_PLOT0: begin
        if (!pl_in || can_take)
          state_next = (dmaj > 5'd1) ? ald_pkg::ST_DIV_GO : ald_pkg::ST_PLOT1;
      end
      ald_pkg::ST_DIV_GO: state_next = ald_pkg::ST_DIV_WAIT;
      ald_pkg::ST_DIV_WAIT: begin
        if (div_done) state_next = ald_pkg::ST_A_RD;
      end
      ald_pkg::ST_A_RD: state_next = b_in ? ald_pkg::ST_A_WR : ald_pkg::ST_B_RD;
      ald_pkg::ST_A_WR: begin
        if (can_take) state_next = ald_pkg::ST_B_RD;
      end
      ald_pkg::ST_B_RD: begin
        if (b_in) state_next = ald_pkg::ST_B_WR;
        else      state_next = last_step ? ald_pkg::ST_PLOT1 : ald_pkg::ST_A_RD;
      end
      ald_pkg::ST_B_WR: begin
        if (can_take) state_next = last_step ? ald_pkg::ST_PLOT1 : ald_pkg::ST_A_RD;
      end
      ald_pkg::ST_PLOT1: begin
        if (!pl_in || can_take) state_next = ald_pkg::ST_FLUSH;
      end
      ald_pkg::ST_RD_ISSUE: state_next = rd_in ? ald_pkg::ST_RD_EMIT : ald_pkg::ST_FLUSH;
      ald_pkg::ST_RD_EMIT: begin
        if (can_take) state_next = ald_pkg::ST_FLUSH;
      end
      ald_pkg::ST_FLUSH: begin
        if (!pend_valid || out_free) state_next = ald_pkg::ST_IDLE;
      end
      default: state_next = ald_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls.
  logic        emit;
  logic        flush_push;
  logic        push;
  logic        advance;
  logic [4:0]  ex, ey;
  logic [23:0] ergb;

  always_comb begin
    emit      = 1'b0;
    re        = 1'b0;
    we        = 1'b0;
    div_start = 1'b0;
    advance   = 1'b0;
    ex        = pl_x;
    ey        = pl_y;
    ergb      = col;
    raddr     = addr_of({1'b0, xs}, {1'b0, ys});
    case (state)
      ald_pkg::ST_PLOT0, ald_pkg::ST_PLOT1: begin
        emit = pl_in && can_take;
        we   = emit;
      end
      ald_pkg::ST_DIV_GO: div_start = 1'b1;
      ald_pkg::ST_A_RD: begin
        re    = b_in;
        raddr = addr_of(bx, by);
      end
      ald_pkg::ST_B_RD: begin
        re      = b_in;
        raddr   = addr_of(bx, by);
        advance = !b_in;
      end
      ald_pkg::ST_A_WR, ald_pkg::ST_B_WR: begin
        emit    = can_take;
        we      = can_take;
        ex      = bx[4:0];
        ey      = by[4:0];
        ergb    = blend_rgb;
        advance = phase_b && can_take;
      end
      ald_pkg::ST_RD_ISSUE: re = rd_in;
      ald_pkg::ST_RD_EMIT: begin
        emit = can_take;
        ex   = xs;
        ey   = ys;
        ergb = rdata;
      end
      ald_pkg::ST_CLEAR: we = 1'b1;
      default: ;
    endcase
    flush_push = (state == ald_pkg::ST_FLUSH) && pend_valid && out_free;
    push       = (emit && pend_valid) || flush_push;
    waddr      = (state == ald_pkg::ST_CLEAR) ? clr_cnt
                                              : addr_of({1'b0, ex}, {1'b0, ey});
    wdata      = (state == ald_pkg::ST_CLEAR) ? '0 : ergb;
  end

  // Frame store ports: write back and registered read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ald_pkg::ST_CLEAR;
      clr_cnt    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ald_pkg::ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      // Hold the newest word back until the next one or the end of the request.
      if (emit)            pend_valid <= 1'b1;
      else if (flush_push) pend_valid <= 1'b0;
      if (push)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rtype <= req_type;
      xs    <= x_start;
      ys    <= y_start;
      // A pixel write reuses the second endpoint plot.
      xe    <= (req_type == ald_pkg::REQ_LINE) ? x_end : x_start;
      ye    <= (req_type == ald_pkg::REQ_LINE) ? y_end : y_start;
      col   <= color_rgb;
    end
    if (state == ald_pkg::ST_SETUP && rtype == ald_pkg::REQ_LINE) begin
      xdom     <= xdom_c;
      ma0      <= swp ? a1 : a0;
      mi0      <= swp ? n1 : n0;
      dmaj     <= swp ? a0 - a1 : a1 - a0;
      dmin_neg <= dmin_c[5];
      dmin_mag <= dmin_c[5] ? 5'(-dmin_c) : dmin_c[4:0];
    end
    if (state == ald_pkg::ST_DIV_WAIT && div_done) begin
      step <= 5'd1;
      pos  <= (PW'(mi0) << FRAC_BITS) + kslope;
    end else if (advance) begin
      step <= step + 5'd1;
      pos  <= pos + kslope;
    end
    if (emit) begin
      pend_x   <= ex;
      pend_y   <= ey;
      pend_rgb <= ergb;
    end
    if (push) begin
      pix_x   <= pend_x;
      pix_y   <= pend_y;
      pix_rgb <= pend_rgb;
      last    <= flush_push;
    end
  end

endmodule

// ===== hw/rtl/ald_checker.sv =====
// Port-level checks for antialiased_line_drawer and the bind that attaches them.
// Depends on antialiased_line_drawer port names only.
module ald_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  pix_x,
  input logic [4:0]  pix_y,
  input logic [23:0] pix_rgb,
  input logic        last
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pix_x) && $stable(pix_y)
                                && $stable(pix_rgb) && $stable(last))
    else $error("result word changed while stalled");

  // Accepting a request makes the block busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a request was taken");

  // Reset empties the output and starts the clearing sweep.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("output or ready active right after reset");

endmodule

bind antialiased_line_drawer ald_checker u_ald_checker (.*);
